>>> design/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PSO_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: implication does not hold");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PSO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication does not hold");

`endif

>>> design/pso_pkg.sv
// Types and constants shared by the particle update modules.
`default_nettype none

package pso_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RandW    = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned CostW    = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned FracBits = 12;

  // Shared multiplier: signed A operand, unsigned B operand taken one bit a cycle.
  localparam int unsigned MulAW   = 33;
  localparam int unsigned MulBW   = 32;
  localparam int unsigned MulPW   = 65;
  localparam int unsigned MulCntW = 6;
  localparam logic [MulCntW-1:0] MulBitsShort = 6'd16;
  localparam logic [MulCntW-1:0] MulBitsLong  = 6'd32;

  // Velocity accumulator; the three scaled terms stay well inside 40 bits.
  localparam int unsigned VsumW = 40;

  localparam logic [CoordW-1:0] CoordMax = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] CoordMin = 32'h8000_0000;

  localparam logic [GainW-1:0] InertiaReset   = 16'd2867;
  localparam logic [GainW-1:0] CognitiveReset = 16'd8192;
  localparam logic [GainW-1:0] SocialReset    = 16'd8192;

  typedef enum logic [1:0] {
    FUNC_INIT = 2'd0,
    FUNC_MOVE = 2'd1,
    FUNC_BEST = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INERTIA   = 2'd0,
    CFG_COGNITIVE = 2'd1,
    CFG_SOCIAL    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_AXIS,
    ST_BEST,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    STEP_G1,
    STEP_G2,
    STEP_T0,
    STEP_T1,
    STEP_T2,
    STEP_SQ
  } step_e;

  typedef struct packed {
    logic [GainW-1:0] inertia;
    logic [GainW-1:0] cognitive;
    logic [GainW-1:0] social;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [MulCntW-1:0] nbits;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

`default_nettype wire

>>> design/pso_cfg_regs.sv
// Configuration registers for the inertia, cognitive and social gains.
`default_nettype none

module pso_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pso_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pso_pkg::GainW-1:0]   cfg_data_i,
  output pso_pkg::cfg_t               cfg_o
);
  import pso_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INERTIA:   cfg_d.inertia   = cfg_data_i;
        CFG_COGNITIVE: cfg_d.cognitive = cfg_data_i;
        CFG_SOCIAL:    cfg_d.social    = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inertia   <= InertiaReset;
      cfg_q.cognitive <= CognitiveReset;
      cfg_q.social    <= SocialReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> design/pso_serial_mult.sv
// Bit-serial shift-and-add multiplier, signed by unsigned, MSB of B first.
`default_nettype none

module pso_serial_mult (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pso_pkg::mul_ctrl_t                ctrl_i,
  input  logic signed [pso_pkg::MulAW-1:0]  a_i,
  input  logic        [pso_pkg::MulBW-1:0]  b_i,
  output pso_pkg::mul_stat_t                stat_o,
  output logic signed [pso_pkg::MulPW-1:0]  prod_o
);
  import pso_pkg::*;

  logic signed [MulAW-1:0]   a_q, a_d;
  logic        [MulBW-1:0]   b_q, b_d;
  logic signed [MulPW-1:0]   acc_q, acc_d;
  logic signed [MulPW-1:0]   addend;
  logic        [MulCntW-1:0] cnt_q, cnt_d;
  logic                      done_q, done_d;

  always_comb begin
    addend = b_q[MulBW-1] ? {{(MulPW-MulAW){a_q[MulAW-1]}}, a_q} : '0;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      // Left-align the used bits of B so that its top bit is always the next one.
      a_d   = a_i;
      b_d   = b_i << (MulCntW'(MulBW) - ctrl_i.nbits);
      acc_d = '0;
      cnt_d = ctrl_i.nbits;
    end else if (cnt_q != '0) begin
      acc_d  = (acc_q <<< 1) + addend;
      b_d    = b_q << 1;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == MulCntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

`default_nettype wire

>>> design/pso_particle_update.sv
// Each multiply runs on the shared bit-serial multiplier.
// A move runs ten 16-bit and two 32-bit multiplies; an init runs two 32-bit squares.
// A personal best update and an unused code use no multiply.
// One request is in flight at a time; a finished result waits in the output register.
// Reset clears position, velocity, best position and cost, sets the best cost to all ones
// and restores the default gains.
`default_nettype none

module pso_particle_update (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pso_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pso_pkg::GainW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic signed [31:0]          load_x_i,
  input  logic signed [31:0]          load_y_i,
  input  logic signed [31:0]          load_vx_i,
  input  logic signed [31:0]          load_vy_i,
  input  logic signed [31:0]          gbest_x_i,
  input  logic signed [31:0]          gbest_y_i,
  input  logic [15:0]                 rand_cog_x_i,
  input  logic [15:0]                 rand_soc_x_i,
  input  logic [15:0]                 rand_cog_y_i,
  input  logic [15:0]                 rand_soc_y_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          pos_x_o,
  output logic signed [31:0]          pos_y_o,
  output logic signed [31:0]          vel_x_o,
  output logic signed [31:0]          vel_y_o,
  output logic [63:0]                 cost_o,
  output logic [63:0]                 best_cost_o,
  output logic signed [31:0]          best_x_o,
  output logic signed [31:0]          best_y_o,
  output logic                        improved_o,
  output logic                        saturated_o
);
  import pso_pkg::*;

  cfg_t      cfg;
  mul_ctrl_t mul_ctrl;
  mul_stat_t mul_stat;
  logic signed [MulAW-1:0] mul_a;
  logic        [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;
  logic signed [MulPW-1:0] prod_shr;
  logic signed [VsumW-1:0] term;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   axis_q, axis_d;
  func_e  func_q, func_d;

  logic signed [CoordW-1:0] pos_q [2];
  logic signed [CoordW-1:0] pos_d [2];
  logic signed [CoordW-1:0] vel_q [2];
  logic signed [CoordW-1:0] vel_d [2];
  logic signed [CoordW-1:0] best_q [2];
  logic signed [CoordW-1:0] best_d [2];
  logic        [CostW-1:0]  cost_q, cost_d;
  logic        [CostW-1:0]  pbest_cost_q, pbest_cost_d;

  logic signed [CoordW-1:0] gb_q [2];
  logic signed [CoordW-1:0] gb_d [2];
  logic        [RandW-1:0]  rc_q [2];
  logic        [RandW-1:0]  rc_d [2];
  logic        [RandW-1:0]  rs_q [2];
  logic        [RandW-1:0]  rs_d [2];
  logic        [GainW-1:0]  g1_q, g1_d, g2_q, g2_d;
  logic signed [VsumW-1:0]  vsum_q, vsum_d;
  logic        [CostW-1:0]  cacc_q, cacc_d;
  logic                     improved_q, improved_d, sat_q, sat_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [CoordW-1:0] out_pos_q [2];
  logic signed [CoordW-1:0] out_vel_q [2];
  logic signed [CoordW-1:0] out_best_q [2];
  logic        [CostW-1:0]  out_cost_q, out_pbest_q;
  logic                     out_improved_q, out_sat_q;

  logic                     in_acc, out_free, out_load;
  logic signed [CoordW-1:0] pos_cur;
  logic        [CoordW-1:0] pos_abs;
  logic                     v_ovf, p_ovf;
  logic signed [CoordW-1:0] v_clip, p_clip;
  logic        [CoordW:0]   p_sum;
  logic        [CostW-1:0]  cost_sum;

  pso_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pso_serial_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .prod_o (prod)
  );

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_DONE) && out_free;

  assign pos_cur  = pos_q[axis_q];
  assign pos_abs  = pos_cur[CoordW-1] ? (CoordW'(0) - pos_cur) : pos_cur;
  assign prod_shr = prod >>> FracBits;
  assign term     = $signed(prod_shr[VsumW-1:0]);
  assign cost_sum = cacc_q + prod[CostW-1:0];

  // Clipping of the new velocity and position for the axis in hand.
  always_comb begin
    v_ovf  = !((&vsum_q[VsumW-1:CoordW-1]) || !(|vsum_q[VsumW-1:CoordW-1]));
    v_clip = v_ovf ? (vsum_q[VsumW-1] ? CoordMin : CoordMax) : vsum_q[CoordW-1:0];
    p_sum  = {pos_cur[CoordW-1], pos_cur} + {v_clip[CoordW-1], v_clip};
    p_ovf  = p_sum[CoordW] != p_sum[CoordW-1];
    p_clip = p_ovf ? (p_sum[CoordW] ? CoordMin : CoordMax) : p_sum[CoordW-1:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (func_e'(func_i))
            FUNC_INIT: state_d = ST_ISSUE;
            FUNC_MOVE: state_d = ST_ISSUE;
            FUNC_BEST: state_d = ST_BEST;
            FUNC_NOP:  state_d = ST_DONE;
          endcase
        end
      end
      ST_ISSUE: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mul_stat.done) begin
          priority if (step_q == STEP_T2) begin
            state_d = ST_AXIS;
          end else if ((step_q == STEP_SQ) && axis_q) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_ISSUE;
          end
        end
      end
      ST_AXIS: state_d = ST_ISSUE;
      ST_BEST: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and multiplier operands.
  always_comb begin
    in_stall_o     = (state_q != ST_IDLE);
    mul_ctrl.start = (state_q == ST_ISSUE);
    mul_ctrl.nbits = MulBitsShort;
    mul_a          = '0;
    mul_b          = '0;
    unique case (step_q)
      STEP_G1: begin
        mul_a = {{(MulAW-GainW){1'b0}}, cfg.cognitive};
        mul_b = {{(MulBW-RandW){1'b0}}, rc_q[axis_q]};
      end
      STEP_G2: begin
        mul_a = {{(MulAW-GainW){1'b0}}, cfg.social};
        mul_b = {{(MulBW-RandW){1'b0}}, rs_q[axis_q]};
      end
      STEP_T0: begin
        mul_a = {vel_q[axis_q][CoordW-1], vel_q[axis_q]};
        mul_b = {{(MulBW-GainW){1'b0}}, cfg.inertia};
      end
      STEP_T1: begin
        mul_a = {best_q[axis_q][CoordW-1], best_q[axis_q]} - {pos_cur[CoordW-1], pos_cur};
        mul_b = {{(MulBW-GainW){1'b0}}, g1_q};
      end
      STEP_T2: begin
        mul_a = {gb_q[axis_q][CoordW-1], gb_q[axis_q]} - {pos_cur[CoordW-1], pos_cur};
        mul_b = {{(MulBW-GainW){1'b0}}, g2_q};
      end
      STEP_SQ: begin
        mul_ctrl.nbits = MulBitsLong;
        mul_a          = {1'b0, pos_abs};
        mul_b          = pos_abs;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Datapath registers.
  always_comb begin
    step_d       = step_q;
    axis_d       = axis_q;
    func_d       = func_q;
    pos_d        = pos_q;
    vel_d        = vel_q;
    best_d       = best_q;
    cost_d       = cost_q;
    pbest_cost_d = pbest_cost_q;
    gb_d         = gb_q;
    rc_d         = rc_q;
    rs_d         = rs_q;
    g1_d         = g1_q;
    g2_d         = g2_q;
    vsum_d       = vsum_q;
    cacc_d       = cacc_q;
    improved_d   = improved_q;
    sat_d        = sat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_d     = func_e'(func_i);
          axis_d     = 1'b0;
          improved_d = 1'b0;
          sat_d      = 1'b0;
          unique case (func_e'(func_i))
            FUNC_INIT: begin
              pos_d[0]  = load_x_i;
              pos_d[1]  = load_y_i;
              vel_d[0]  = load_vx_i;
              vel_d[1]  = load_vy_i;
              best_d[0] = load_x_i;
              best_d[1] = load_y_i;
              step_d    = STEP_SQ;
            end
            FUNC_MOVE: begin
              gb_d[0] = gbest_x_i;
              gb_d[1] = gbest_y_i;
              rc_d[0] = rand_cog_x_i;
              rc_d[1] = rand_cog_y_i;
              rs_d[0] = rand_soc_x_i;
              rs_d[1] = rand_soc_y_i;
              step_d  = STEP_G1;
            end
            FUNC_BEST: step_d = step_q;
            FUNC_NOP:  step_d = step_q;
          endcase
        end
      end
      ST_WAIT: begin
        if (mul_stat.done) begin
          unique case (step_q)
            STEP_G1: begin
              g1_d   = prod[2*GainW-1:GainW];
              step_d = STEP_G2;
            end
            STEP_G2: begin
              g2_d   = prod[2*GainW-1:GainW];
              step_d = STEP_T0;
            end
            STEP_T0: begin
              vsum_d = term;
              step_d = STEP_T1;
            end
            STEP_T1: begin
              vsum_d = vsum_q + term;
              step_d = STEP_T2;
            end
            STEP_T2: vsum_d = vsum_q + term;
            STEP_SQ: begin
              if (!axis_q) begin
                cacc_d = prod[CostW-1:0];
                axis_d = 1'b1;
              end else begin
                cost_d = cost_sum;
                axis_d = 1'b0;
                // An init takes its own cost as the best so far.
                if (func_q == FUNC_INIT) begin
                  pbest_cost_d = cost_sum;
                end
              end
            end
            default: step_d = step_q;
          endcase
        end
      end
      ST_AXIS: begin
        vel_d[axis_q] = v_clip;
        pos_d[axis_q] = p_clip;
        sat_d         = sat_q || v_ovf || p_ovf;
        if (!axis_q) begin
          axis_d = 1'b1;
          step_d = STEP_G1;
        end else begin
          axis_d = 1'b0;
          step_d = STEP_SQ;
        end
      end
      ST_BEST: begin
        if (cost_q < pbest_cost_q) begin
          best_d       = pos_q;
          pbest_cost_d = cost_q;
          improved_d   = 1'b1;
        end
      end
      default: step_d = step_q;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= STEP_G1;
      axis_q       <= 1'b0;
      func_q       <= FUNC_NOP;
      pos_q        <= '{default: '0};
      vel_q        <= '{default: '0};
      best_q       <= '{default: '0};
      cost_q       <= '0;
      pbest_cost_q <= '1;
      improved_q   <= 1'b0;
      sat_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      axis_q       <= axis_d;
      func_q       <= func_d;
      pos_q        <= pos_d;
      vel_q        <= vel_d;
      best_q       <= best_d;
      cost_q       <= cost_d;
      pbest_cost_q <= pbest_cost_d;
      improved_q   <= improved_d;
      sat_q        <= sat_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gb_q   <= gb_d;
    rc_q   <= rc_d;
    rs_q   <= rs_d;
    g1_q   <= g1_d;
    g2_q   <= g2_d;
    vsum_q <= vsum_d;
    cacc_q <= cacc_d;
    if (out_load) begin
      out_pos_q      <= pos_q;
      out_vel_q      <= vel_q;
      out_best_q     <= best_q;
      out_cost_q     <= cost_q;
      out_pbest_q    <= pbest_cost_q;
      out_improved_q <= improved_q;
      out_sat_q      <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_pos_q[0];
  assign pos_y_o     = out_pos_q[1];
  assign vel_x_o     = out_vel_q[0];
  assign vel_y_o     = out_vel_q[1];
  assign cost_o      = out_cost_q;
  assign best_cost_o = out_pbest_q;
  assign best_x_o    = out_best_q[0];
  assign best_y_o    = out_best_q[1];
  assign improved_o  = out_improved_q;
  assign saturated_o = out_sat_q;

endmodule

`default_nettype wire

>>> design/pso_checker.sv
// Port-level checks on the particle update block, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module pso_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [pso_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [pso_pkg::GainW-1:0]   cfg_data_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  func_i,
  input logic signed [31:0]          load_x_i,
  input logic signed [31:0]          load_y_i,
  input logic signed [31:0]          load_vx_i,
  input logic signed [31:0]          load_vy_i,
  input logic signed [31:0]          gbest_x_i,
  input logic signed [31:0]          gbest_y_i,
  input logic [15:0]                 rand_cog_x_i,
  input logic [15:0]                 rand_soc_x_i,
  input logic [15:0]                 rand_cog_y_i,
  input logic [15:0]                 rand_soc_y_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [31:0]          pos_x_o,
  input logic signed [31:0]          pos_y_o,
  input logic signed [31:0]          vel_x_o,
  input logic signed [31:0]          vel_y_o,
  input logic [63:0]                 cost_o,
  input logic [63:0]                 best_cost_o,
  input logic signed [31:0]          best_x_o,
  input logic signed [31:0]          best_y_o,
  input logic                        improved_o,
  input logic                        saturated_o
);

  logic best_is_current;

  assign best_is_current = (best_cost_o == cost_o) && (best_x_o == pos_x_o) &&
                           (best_y_o == pos_y_o);

  // Only one request is worked on at a time, so an accepted one blocks the next.
  `PSO_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // A result that is held back stays offered.
  `PSO_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // A replaced personal best is the current position and its cost.
  `PSO_ASSERT_IMPL(a_improved_match, out_valid_o && improved_o, best_is_current)

  // Only a move can clip and only an update can improve.
  `PSO_ASSERT_IMPL(a_flags_exclusive, out_valid_o, !(improved_o && saturated_o))

endmodule

bind pso_particle_update pso_checker u_pso_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the two-dimensional particle update block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pso_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 300;
  localparam longint CoordHi   = 2147483647;
  localparam longint CoordLo   = -CoordHi - 1;

  typedef struct {
    func_e              func;
    logic signed [31:0] load_x, load_y, load_vx, load_vy;
    logic signed [31:0] gbest_x, gbest_y;
    logic [15:0]        rand_cog_x, rand_soc_x, rand_cog_y, rand_soc_y;
  } particle_req_t;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [63:0]        cost, best_cost;
    logic signed [31:0] best_x, best_y;
    logic               improved, saturated;
  } particle_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [GainW-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           func_i;
  logic signed [31:0]   load_x_i, load_y_i, load_vx_i, load_vy_i;
  logic signed [31:0]   gbest_x_i, gbest_y_i;
  logic [15:0]          rand_cog_x_i, rand_soc_x_i, rand_cog_y_i, rand_soc_y_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [31:0]   pos_x_o, pos_y_o, vel_x_o, vel_y_o;
  logic [63:0]          cost_o, best_cost_o;
  logic signed [31:0]   best_x_o, best_y_o;
  logic                 improved_o, saturated_o;

  // Predicted particle state and gain settings.
  logic signed [31:0]   part_pos [2];
  logic signed [31:0]   part_vel [2];
  logic signed [31:0]   part_best [2];
  logic [63:0]          part_cost, part_best_cost;
  logic [GainW-1:0]     w_inertia, w_cognitive, w_social;

  particle_res_t        expected_q [$];
  int                   error_count = 0;
  bit                   no_idle = 1'b0;
  bit                   tx_active = 1'b0;
  int                   rx_hold_cnt = 0;

  pso_particle_update DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .load_x_i     (load_x_i),
    .load_y_i     (load_y_i),
    .load_vx_i    (load_vx_i),
    .load_vy_i    (load_vy_i),
    .gbest_x_i    (gbest_x_i),
    .gbest_y_i    (gbest_y_i),
    .rand_cog_x_i (rand_cog_x_i),
    .rand_soc_x_i (rand_soc_x_i),
    .rand_cog_y_i (rand_cog_y_i),
    .rand_soc_y_i (rand_soc_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .vel_x_o      (vel_x_o),
    .vel_y_o      (vel_y_o),
    .cost_o       (cost_o),
    .best_cost_o  (best_cost_o),
    .best_x_o     (best_x_o),
    .best_y_o     (best_y_o),
    .improved_o   (improved_o),
    .saturated_o  (saturated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic signed [31:0] clip_coord(input longint v, inout bit sat);
    if (v > CoordHi) begin
      sat = 1'b1;
      return CoordMax;
    end
    if (v < CoordLo) begin
      sat = 1'b1;
      return CoordMin;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] sq_mag(input logic signed [31:0] c);
    longint m;
    m = c;
    if (m < 0) m = -m;
    return m * m;
  endfunction

  function automatic particle_res_t predict_step(input particle_req_t r);
    particle_res_t e;
    longint        p, v, b, gb, rc, rs, g1, g2, t0, t1, t2;
    longint        iw, cg, sg;
    bit            sat;
    bit            better;
    sat    = 1'b0;
    better = 1'b0;
    iw = w_inertia;
    cg = w_cognitive;
    sg = w_social;
    case (r.func)
      FUNC_INIT: begin
        part_pos[0] = r.load_x;
        part_pos[1] = r.load_y;
        part_vel[0] = r.load_vx;
        part_vel[1] = r.load_vy;
        part_best   = part_pos;
        part_cost   = sq_mag(part_pos[0]) + sq_mag(part_pos[1]);
        part_best_cost = part_cost;
      end
      FUNC_MOVE: begin
        for (int d = 0; d < 2; d++) begin
          p  = part_pos[d];
          v  = part_vel[d];
          b  = part_best[d];
          gb = (d == 0) ? r.gbest_x : r.gbest_y;
          rc = (d == 0) ? r.rand_cog_x : r.rand_cog_y;
          rs = (d == 0) ? r.rand_soc_x : r.rand_soc_y;
          g1 = (cg * rc) >>> 16;
          g2 = (sg * rs) >>> 16;
          // Arithmetic shifts of signed values round toward minus infinity.
          t0 = (iw * v) >>> FracBits;
          t1 = (g1 * (b - p)) >>> FracBits;
          t2 = (g2 * (gb - p)) >>> FracBits;
          part_vel[d] = clip_coord(t0 + t1 + t2, sat);
          part_pos[d] = clip_coord(p + part_vel[d], sat);
        end
        part_cost = sq_mag(part_pos[0]) + sq_mag(part_pos[1]);
      end
      FUNC_BEST: begin
        if (part_cost < part_best_cost) begin
          part_best      = part_pos;
          part_best_cost = part_cost;
          better         = 1'b1;
        end
      end
      default: ;
    endcase
    e.pos_x     = part_pos[0];
    e.pos_y     = part_pos[1];
    e.vel_x     = part_vel[0];
    e.vel_y     = part_vel[1];
    e.cost      = part_cost;
    e.best_cost = part_best_cost;
    e.best_x    = part_best[0];
    e.best_y    = part_best[1];
    e.improved  = better;
    e.saturated = sat;
    return e;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    logic [23:0] frac;
    frac = 24'($urandom);
    case ($urandom_range(0, 9))
      0:       return CoordMax;
      1:       return CoordMin;
      2, 3, 4: return $urandom;
      // Modest magnitudes in half the draws, so that the swarm settles and improves.
      default: return {{8{frac[23]}}, frac};
    endcase
  endfunction

  function automatic logic [15:0] rand_factor();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic particle_req_t make_req(input func_e f);
    particle_req_t r;
    r.func       = f;
    r.load_x     = rand_coord();
    r.load_y     = rand_coord();
    r.load_vx    = rand_coord();
    r.load_vy    = rand_coord();
    r.gbest_x    = rand_coord();
    r.gbest_y    = rand_coord();
    r.rand_cog_x = rand_factor();
    r.rand_soc_x = rand_factor();
    r.rand_cog_y = rand_factor();
    r.rand_soc_y = rand_factor();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Valid stays high across back-to-back requests; it is lowered only for a gap or to finish.
  task automatic send_request(input particle_req_t r);
    int gap;
    gap = ($urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap != 0) begin
      if (tx_active) begin
        in_valid_i <= 1'b0;
        tx_active = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    tx_active     = 1'b1;
    func_i       <= r.func;
    load_x_i     <= r.load_x;
    load_y_i     <= r.load_y;
    load_vx_i    <= r.load_vx;
    load_vy_i    <= r.load_vy;
    gbest_x_i    <= r.gbest_x;
    gbest_y_i    <= r.gbest_y;
    rand_cog_x_i <= r.rand_cog_x;
    rand_soc_x_i <= r.rand_soc_x;
    rand_cog_y_i <= r.rand_cog_y;
    rand_soc_y_i <= r.rand_soc_y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_step(r));
  endtask

  task automatic finish_requests();
    if (tx_active) begin
      in_valid_i <= 1'b0;
      tx_active = 1'b0;
    end
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_gains(input logic [15:0] iw, input logic [15:0] cg,
                           input logic [15:0] sg);
    logic [15:0] vals [3];
    cfg_idx_e    idx;
    finish_requests();
    vals = '{iw, cg, sg};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      idx = cfg_idx_e'(i);
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx)
        CFG_INERTIA:   w_inertia   = vals[i];
        CFG_COGNITIVE: w_cognitive = vals[i];
        CFG_SOCIAL:    w_social    = vals[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Unused code, then a best update against the all-ones reset cost, then a move and a best update.
  task automatic test_reset_state();
    send_request(make_req(FUNC_NOP));
    send_request(make_req(FUNC_BEST));
    send_request(make_req(FUNC_MOVE));
    send_request(make_req(FUNC_BEST));
  endtask

  task automatic test_init_extremes();
    particle_req_t r;
    r = make_req(FUNC_INIT);
    r.load_x  = CoordMax;
    r.load_y  = CoordMax;
    r.load_vx = CoordMax;
    r.load_vy = CoordMin;
    send_request(r);
    // An equal cost must not replace the personal best.
    send_request(make_req(FUNC_BEST));
    r = make_req(FUNC_MOVE);
    r.gbest_x    = CoordMax;
    r.gbest_y    = CoordMin;
    r.rand_cog_x = 16'hFFFF;
    r.rand_soc_x = 16'hFFFF;
    r.rand_cog_y = 16'hFFFF;
    r.rand_soc_y = 16'hFFFF;
    send_request(r);
    send_request(make_req(FUNC_BEST));
    r = make_req(FUNC_INIT);
    r.load_x  = CoordMin;
    r.load_y  = CoordMin;
    r.load_vx = CoordMin;
    r.load_vy = CoordMax;
    send_request(r);
    r = make_req(FUNC_MOVE);
    r.gbest_x    = CoordMax;
    r.gbest_y    = CoordMax;
    r.rand_cog_x = 16'h0000;
    r.rand_soc_x = 16'hFFFF;
    r.rand_cog_y = 16'hFFFF;
    r.rand_soc_y = 16'h0000;
    send_request(r);
    send_request(make_req(FUNC_BEST));
    send_request(make_req(FUNC_NOP));
    r = make_req(FUNC_INIT);
    r.load_x  = '0;
    r.load_y  = '0;
    r.load_vx = '0;
    r.load_vy = '0;
    send_request(r);
    send_request(make_req(FUNC_BEST));
    send_request(make_req(FUNC_MOVE));
  endtask

  task automatic test_gain_extremes();
    particle_req_t r;
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(make_req(FUNC_INIT));
    r = make_req(FUNC_MOVE);
    r.gbest_x = CoordMin;
    r.gbest_y = CoordMax;
    send_request(r);
    send_request(make_req(FUNC_MOVE));
    send_request(make_req(FUNC_BEST));
    set_gains(16'h0000, 16'h0000, 16'h0000);
    send_request(make_req(FUNC_MOVE));
    send_request(make_req(FUNC_MOVE));
    send_request(make_req(FUNC_BEST));
  endtask

  // Mostly well-formed particle lives: init, then moves each usually followed
  // by a best update; the rest is requests with a random code.
  task automatic run_swarm(input int n_items);
    int sent;
    int steps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        send_request(make_req(FUNC_INIT));
        sent++;
        steps = $urandom_range(1, 8);
        repeat (steps) begin
          send_request(make_req(FUNC_MOVE));
          sent++;
          if ($urandom_range(0, 4) != 0) begin
            send_request(make_req(FUNC_BEST));
            sent++;
          end
        end
      end else begin
        send_request(make_req(func_e'($urandom_range(0, 3))));
        sent++;
      end
    end
  endtask

  task automatic test_random_swarm();
    set_gains(InertiaReset, CognitiveReset, SocialReset);
    run_swarm(150);
    set_gains(16'($urandom), 16'($urandom), 16'($urandom));
    run_swarm(150);
    set_gains(16'hFFFF, 16'h0000, 16'hFFFF);
    run_swarm(100);
    set_gains(16'h0000, 16'hFFFF, 16'h0000);
    run_swarm(100);
    no_idle = 1'b1;
    set_gains(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 8192)),
              16'($urandom_range(0, 8192)));
    run_swarm(150);
    no_idle = 1'b0;
    set_gains(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 16384)),
              16'($urandom_range(0, 16384)));
    run_swarm(250);
  endtask

  always @(posedge clk_i) begin
    if (rx_hold_cnt == 0 && !no_idle && $urandom_range(0, 3) == 0)
      rx_hold_cnt = gap_len();
    out_stall_i <= (rx_hold_cnt != 0);
    if (rx_hold_cnt != 0) rx_hold_cnt--;
  end

  always @(posedge clk_i) begin : result_check
    particle_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request pending", cost_o, '0);
      end else begin
        e = expected_q.pop_front();
        check_field("pos_x", pos_x_o, e.pos_x);
        check_field("pos_y", pos_y_o, e.pos_y);
        check_field("vel_x", vel_x_o, e.vel_x);
        check_field("vel_y", vel_y_o, e.vel_y);
        check_field("cost", cost_o, e.cost);
        check_field("best_cost", best_cost_o, e.best_cost);
        check_field("best_x", best_x_o, e.best_x);
        check_field("best_y", best_y_o, e.best_y);
        check_field("improved", improved_o, e.improved);
        check_field("saturated", saturated_o, e.saturated);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= CFG_INERTIA;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    func_i       <= FUNC_INIT;
    load_x_i     <= '0;
    load_y_i     <= '0;
    load_vx_i    <= '0;
    load_vy_i    <= '0;
    gbest_x_i    <= '0;
    gbest_y_i    <= '0;
    rand_cog_x_i <= '0;
    rand_soc_x_i <= '0;
    rand_cog_y_i <= '0;
    rand_soc_y_i <= '0;
    w_inertia      = InertiaReset;
    w_cognitive    = CognitiveReset;
    w_social       = SocialReset;
    part_pos       = '{0, 0};
    part_vel       = '{0, 0};
    part_best      = '{0, 0};
    part_cost      = '0;
    part_best_cost = '1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_init_extremes();
    test_gain_extremes();
    test_random_swarm();

    finish_requests();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
